FILE: hdl/cpg_pkg.sv
// Shared constants and types for the circle point generator.
// No dependencies.
package cpg_pkg;

    localparam int TABLE_LEN         = 24;
    localparam int DEF_CORDIC_STAGES = 16;

    // datapath widths
    localparam int TIME_W  = 16;
    localparam int RAD_W   = 16;
    localparam int SPEED_W = 32;
    localparam int PHASE_W = 24;
    localparam int ANG_W   = 32;
    localparam int XY_W    = 42;
    localparam int OUT_W   = 17;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // 1/K of an infinite CORDIC, Q0.32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    localparam logic [ANG_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS      = 2'd0,
        REG_SPEED       = 2'd1,
        REG_START_PHASE = 2'd2
    } cfg_reg_t;

endpackage

FILE: hdl/circle_point_generator_top.sv
// Circle point generator: phase ramp followed by a pipelined rotation-mode CORDIC.
// Depends on cpg_pkg.
//
// Usage:
//   Configuration: cfg_wr_en writes cfg_data into the register cfg_index
//   (0 radius Q8.8, 1 speed, 2 start phase, both in 2^-24 turn). Unknown
//   indexes are ignored. Write only while no word is in flight.
//   Input channel: in_valid/in_ready carry one time_index per word.
//   Output channel: out_valid/out_ready carry x_pos, y_pos (signed Q8.8),
//   radius times cos/sin of (time_index*speed + start_phase).
//   Pipeline registers: the multiply stage, the angle/gain stage, one
//   register per CORDIC micro-rotation and the rounding output register.
//   Throughput: one word per cycle while the receiver takes results.
//   Stall: when out_valid is high and out_ready low, the whole pipeline
//   holds and in_ready drops; nothing is lost or repeated.
//   Reset: pipeline empties, all configuration registers clear to zero.
//   Stage counts above 24 behave as 24.
module circle_point_generator_top #(
    parameter int CORDIC_STAGES = cpg_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cpg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cpg_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cpg_pkg::TIME_W-1:0]           time_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [cpg_pkg::OUT_W-1:0]     x_pos,
    output logic signed [cpg_pkg::OUT_W-1:0]     y_pos
);
    import cpg_pkg::*;

    localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int PROD_W = TIME_W + PHASE_W;
    localparam int GPROD_W = RAD_W + 32;
    localparam logic signed [XY_W-1:0] SAT_MAX = XY_W'(65535);
    localparam logic signed [XY_W-1:0] SAT_MIN = -XY_W'(65535);

    // configuration
    logic [RAD_W-1:0]   radius_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [PHASE_W-1:0] start_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= '0;
            speed_reg       <= '0;
            start_phase_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS:      radius_reg      <= cfg_data[RAD_W-1:0];
                REG_SPEED:       speed_reg       <= cfg_data[SPEED_W-1:0];
                REG_START_PHASE: start_phase_reg <= cfg_data[PHASE_W-1:0];
                default:         ;
            endcase
        end
    end

    // global advance: pipeline moves unless the output word is stalled
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage A: phase product and gain-scaled radius
    logic                 vld_a_reg;
    logic [PHASE_W-1:0]   prod_reg;
    logic [GPROD_W-1:0]   xg_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [GPROD_W-1:0]   xg_next;

    assign prod_next = time_index * speed_reg[PHASE_W-1:0];
    assign xg_next   = radius_reg * GAIN_Q32;

    // stage B onward: CORDIC vectors, index k holds the input of micro-rotation k
    logic                    vld_reg [0:NSTG];
    logic signed [XY_W-1:0]  x_reg   [0:NSTG];
    logic signed [XY_W-1:0]  y_reg   [0:NSTG];
    logic signed [ANG_W-1:0] z_reg   [0:NSTG-1];
    logic [1:0]              q_reg   [0:NSTG];

    logic [PHASE_W-1:0]   phase_next;
    logic [PHASE_W-1:0]   qsum_next;
    logic [1:0]           q_next;
    logic [ANG_W-1:0]     resid_next;
    logic [GPROD_W:0]     xr_next;

    assign phase_next = prod_reg + start_phase_reg;
    assign qsum_next  = phase_next + PHASE_W'(24'h200000);
    assign q_next     = qsum_next[PHASE_W-1 -: 2];
    assign resid_next = {phase_next, 8'b0} - {q_next, 30'b0};
    assign xr_next    = {1'b0, xg_reg} + (GPROD_W+1)'(32768);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg  <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_a_reg  <= in_valid;
            vld_reg[0] <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next[PHASE_W-1:0];
            xg_reg   <= xg_next;
            x_reg[0] <= XY_W'(xr_next[GPROD_W:16]);
            y_reg[0] <= '0;
            z_reg[0] <= resid_next;
            q_reg[0] <= q_next;
        end
    end

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic                   pos;

        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign pos = !z_reg[i][ANG_W-1];

        assign x_next = pos ? x_reg[i] - dx : x_reg[i] + dx;
        assign y_next = pos ? y_reg[i] + dy : y_reg[i] - dy;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                q_reg[i+1] <= q_reg[i];
            end
        end

        if (i < NSTG - 1)
        begin : g_z
            logic signed [ANG_W-1:0] z_next;
            assign z_next = pos ? z_reg[i] - $signed(ATAN_TABLE[i])
                                : z_reg[i] + $signed(ATAN_TABLE[i]);
            always_ff @(posedge clk)
            begin
                if (adv)
                    z_reg[i+1] <= z_next;
            end
        end
    end

    // quadrant fold, round half up, saturate
    logic signed [XY_W-1:0] xo;
    logic signed [XY_W-1:0] yo;
    logic signed [XY_W-1:0] xr;
    logic signed [XY_W-1:0] yr;
    logic signed [OUT_W-1:0] x_sat_next;
    logic signed [OUT_W-1:0] y_sat_next;

    always_comb
    begin
        case (q_reg[NSTG])
            2'd1:    begin xo = -y_reg[NSTG]; yo =  x_reg[NSTG]; end
            2'd2:    begin xo = -x_reg[NSTG]; yo = -y_reg[NSTG]; end
            2'd3:    begin xo =  y_reg[NSTG]; yo = -x_reg[NSTG]; end
            default: begin xo =  x_reg[NSTG]; yo =  y_reg[NSTG]; end
        endcase
    end

    assign xr = (xo + XY_W'(32768)) >>> 16;
    assign yr = (yo + XY_W'(32768)) >>> 16;

    assign x_sat_next = (xr > SAT_MAX) ? OUT_W'(SAT_MAX) :
                        (xr < SAT_MIN) ? OUT_W'(SAT_MIN) : xr[OUT_W-1:0];
    assign y_sat_next = (yr > SAT_MAX) ? OUT_W'(SAT_MAX) :
                        (yr < SAT_MIN) ? OUT_W'(SAT_MIN) : yr[OUT_W-1:0];

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] x_pos_reg;
    logic signed [OUT_W-1:0] y_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_pos_reg <= x_sat_next;
            y_pos_reg <= y_sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_pos     = x_pos_reg;
    assign y_pos     = y_pos_reg;

    // checks
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_a_reg)
        else $error("accepted word did not enter the pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (out_valid == $past(vld_reg[NSTG])))
        else $error("last stage valid not carried to output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vld_a_reg) && $stable(vld_reg[0])))
        else $error("pipeline moved while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (x_pos != -OUT_W'(65536)) && (y_pos != -OUT_W'(65536)))
        else $error("output outside saturation range");

endmodule
